[rtl/core/lgs_pkg.sv]
// Shared constants, types and helpers for the life grid generation step.
package lgs_pkg;

  localparam int MAX_COLS   = 64;
  localparam int COL_W      = 7;
  localparam int NBR_W      = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // How many rows of the current grid are held in the row registers.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  typedef logic [MAX_COLS-1:0] row_t;

  typedef struct packed {
    logic done;
    row_t cells;
  } out_word_t;

  // Up to two result words written into the output queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  // Bit c is set when column c is in use; counts above MAX_COLS act as MAX_COLS.
  function automatic row_t col_mask(input logic [COL_W-1:0] cols);
    row_t m;
    for (int c = 0; c < MAX_COLS; c++) begin
      m[c] = (COL_W'(c) < cols);
    end
    return m;
  endfunction

endpackage

[rtl/core/lgs_cell_lane.sv]
// One cell of the B3/S23 rule: neighbor count and birth/survival decision.
module lgs_cell_lane (
  input  logic [2:0] up3,
  input  logic [2:0] mid3,
  input  logic [2:0] dn3,
  output logic       alive
);
  import lgs_pkg::*;

  logic [NBR_W-1:0] count;

  assign count = NBR_W'(up3[0]) + NBR_W'(up3[1]) + NBR_W'(up3[2])
               + NBR_W'(mid3[0]) + NBR_W'(mid3[2])
               + NBR_W'(dn3[0]) + NBR_W'(dn3[1]) + NBR_W'(dn3[2]);

  assign alive = (count == NBR_W'(3)) || (mid3[1] && (count == NBR_W'(2)));

endmodule

[rtl/core/lgs_row_engine.sv]
// Next generation of one row: one cell lane per column, merged into a masked row.
module lgs_row_engine (
  input  lgs_pkg::row_t up,
  input  lgs_pkg::row_t mid,
  input  lgs_pkg::row_t dn,
  input  lgs_pkg::row_t mask,
  output lgs_pkg::row_t next
);
  import lgs_pkg::*;

  // Zero padding on both sides keeps neighbors from crossing the row edges.
  logic [MAX_COLS+1:0] up_pad;
  logic [MAX_COLS+1:0] mid_pad;
  logic [MAX_COLS+1:0] dn_pad;
  row_t                lane_out;

  assign up_pad  = {1'b0, up  & mask, 1'b0};
  assign mid_pad = {1'b0, mid & mask, 1'b0};
  assign dn_pad  = {1'b0, dn  & mask, 1'b0};

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    lgs_cell_lane u_lane (
      .up3  (up_pad[c+2:c]),
      .mid3 (mid_pad[c+2:c]),
      .dn3  (dn_pad[c+2:c]),
      .alive(lane_out[c])
    );
  end

  assign next = lane_out & mask;

endmodule

[rtl/core/lgs_out_fifo.sv]
// Small output queue that takes up to two result words per cycle.
module lgs_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  lgs_pkg::push_t             push,
  input  logic                       pop,
  output logic                       valid,
  output lgs_pkg::out_word_t         head,
  output logic                       room2,
  output logic [lgs_pkg::FCNT_W-1:0] count
);
  import lgs_pkg::*;

  out_word_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign valid  = (count != '0);
  assign do_pop = pop && valid;
  assign head   = mem[rd_ptr];
  assign room2  = (count <= FCNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.w0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.n);
      rd_ptr <= rd_ptr + PTR_W'(do_pop);
      count  <= count + FCNT_W'(push.n) - FCNT_W'(do_pop);
    end
  end

endmodule

[rtl/core/life_grid_generation_step_top.sv]
// Top level of the life grid generation step: row registers, two row engines, output queue.
//
// Computes one generation of a B3/S23 life grid as it streams past. Rows of the
// current generation enter on the slave stream, top to bottom, one 64-bit word
// per row (bit c is column c, 1 alive), with tlast on the bottom row. Each
// next-generation row leaves on the master stream one row late: the row that
// arrives completes the row above it. The bottom row yields two words, the row
// above it and then the bottom row itself with tlast set, which also flushes the
// block for the next grid; a grid of a single row yields one word with tlast.
// Cells outside the grid count as dead and nothing wraps across row edges.
// Columns at or above grid_cols are ignored on input and read zero on output.
// Rate: one row per clock while the queue has room for two words. All 64 cell
// rules are evaluated side by side by two row engines, so a result word is
// written into a four-word output queue in the same cycle the row is taken, and
// it can leave in the next cycle. A row is taken whenever the queue has room for
// two words, so with the master side always ready the block never stalls; when
// the master side stalls, the queue takes three or four words before tready falls.
// grid_cols resets to 64 and is written on the cfg channel, which is always
// ready; write it only between grids.
module life_grid_generation_step_top (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write channel: grid_cols.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lgs_pkg::COL_W-1:0] cfg_data,   // grid_cols
  // Row stream in.
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // [63:0] row_cells
  input  logic                      s_axis_tlast,  // last_row
  // Next-generation stream out.
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [63:0]               m_axis_tdata,  // [63:0] next_cells
  output logic                      m_axis_tlast   // grid_done
);
  import lgs_pkg::*;

  logic [COL_W-1:0]  grid_cols;
  row_t              upper_row;
  row_t              middle_row;
  logic [1:0]        rows_held;
  row_t              mask;
  row_t              in_row;
  row_t              next_mid;
  row_t              next_last;
  logic              accept;
  push_t             push;
  out_word_t         head;
  logic              fifo_room2;
  logic [FCNT_W-1:0] fifo_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= COL_W'(MAX_COLS);
    end else if (cfg_valid && cfg_ready) begin
      grid_cols <= cfg_data;
    end
  end

  assign mask          = col_mask(grid_cols);
  assign in_row        = s_axis_tdata & mask;
  assign s_axis_tready = fifo_room2;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Row above the incoming one, finished now that its lower neighbor is here.
  lgs_row_engine u_eng_mid (
    .up  (upper_row),
    .mid (middle_row),
    .dn  (in_row),
    .mask(mask),
    .next(next_mid)
  );

  // Incoming row as the bottom of the grid; middle_row is zero for a one-row grid.
  lgs_row_engine u_eng_last (
    .up  (middle_row),
    .mid (in_row),
    .dn  ('0),
    .mask(mask),
    .next(next_last)
  );

  always_comb begin
    push.w1 = '{done: 1'b1, cells: next_last};
    if (rows_held == HELD_NONE) begin
      push.w0 = '{done: 1'b1, cells: next_last};
      push.n  = (accept && s_axis_tlast) ? 2'd1 : 2'd0;
    end else begin
      push.w0 = '{done: 1'b0, cells: next_mid};
      push.n  = !accept ? 2'd0 : (s_axis_tlast ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row  <= '0;
      middle_row <= '0;
      rows_held  <= HELD_NONE;
    end else if (accept) begin
      if (s_axis_tlast) begin
        upper_row  <= '0;
        middle_row <= '0;
        rows_held  <= HELD_NONE;
      end else if (rows_held == HELD_NONE) begin
        upper_row  <= '0;
        middle_row <= in_row;
        rows_held  <= HELD_ONE;
      end else begin
        upper_row  <= middle_row;
        middle_row <= in_row;
        rows_held  <= HELD_TWO;
      end
    end
  end

  lgs_out_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (m_axis_tready),
    .valid(m_axis_tvalid),
    .head (head),
    .room2(fifo_room2),
    .count(fifo_count)
  );

  assign m_axis_tdata = head.cells;
  assign m_axis_tlast = head.done;

  // The queue never holds more words than it has entries.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FCNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  // A bottom row returns the row registers to the empty state.
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (rows_held == HELD_NONE))
    else $error("row registers not flushed after last row");

  // With no row held, both row registers are empty.
  a_empty_rows: assert property (@(posedge clk) disable iff (rst)
    (rows_held == HELD_NONE) |-> (upper_row == '0 && middle_row == '0))
    else $error("stale row data with no row held");

  // Only one row held means no row above it yet.
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    (rows_held == HELD_ONE) |-> (upper_row == '0))
    else $error("upper row set with a single row held");

endmodule
